// ===== hdl/scf_pkg.sv =====
// ----------------------------------------------------------------------------
// scf_pkg: shared types and constants for the framed receiver
//
// Holds the byte type and the fixed widths of the frame receiver payload.
// ----------------------------------------------------------------------------
package scf_pkg;

  localparam int BYTE_W = 8;
  localparam int IDX_W  = 6;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [IDX_W-1:0]  idx_t;

  // Sync byte value after reset
  localparam byte_t SYNC_RESET = 8'hFF;

endpackage

// ===== hdl/sync_checksum_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// sync_checksum_frame_receiver: sync-byte framed receiver with sum check
//
// Collects bytes into frames that start with the sync byte, checks the
// additive checksum and streams out good frames byte by byte.
// ----------------------------------------------------------------------------
// A received byte is taken whenever the block is idle: bytes are dropped
// until the sync byte opens a frame, then appended to the frame store. The
// byte that fills the store to FRAME_BYTES starts a check pass that streams
// bytes 1 to FRAME_BYTES-1 through the store's single read port. A good frame
// then leaves byte by byte while the sink is ready; the next byte is read
// only once the output register is empty or its beat is taken (the read
// port feeds the output register). A bad frame whose tail holds another
// sync byte at position k is moved to the front; otherwise the store is
// emptied at once. No input beat is taken during the check, the move or the
// output of a frame. The store needs no clearing pass after reset. The sync
// byte may be written only while the block is idle.
module sync_checksum_frame_receiver #(
  parameter int FRAME_BYTES = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  scf_pkg::byte_t  cfg_wr_data,
  input  logic            in_valid,
  output logic            in_ready,
  input  scf_pkg::byte_t  in_rx_byte,
  output logic            out_valid,
  input  logic            out_ready,
  output scf_pkg::byte_t  out_frame_byte,
  output scf_pkg::idx_t   out_byte_index,
  output logic            out_last_of_frame
);
  import scf_pkg::*;

  localparam int AW = $clog2(FRAME_BYTES);
  localparam int CW = $clog2(FRAME_BYTES + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(FRAME_BYTES - 1);
  localparam logic [AW-1:0] CK_ADDR   = AW'(1);
  localparam logic [CW-1:0] FILL_LAST = CW'(FRAME_BYTES - 1);
  localparam logic [CW-1:0] FILL_FULL = CW'(FRAME_BYTES);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_COPY  = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  byte_t         sync_r;
  logic [AW-1:0] scan_addr_r, scan_addr_nxt;
  logic          issue_r, issue_nxt;
  logic          dv_r, dv_nxt;
  logic [AW-1:0] d_idx_r, d_idx_nxt;
  byte_t         sum_r, sum_nxt;
  byte_t         ck_r, ck_nxt;
  logic          found_r, found_nxt;
  logic [AW-1:0] found_idx_r, found_idx_nxt;
  logic [AW-1:0] dst_r, dst_nxt;
  logic          out_valid_r, out_valid_nxt;
  byte_t         out_byte_r, out_byte_nxt;
  idx_t          out_idx_r, out_idx_nxt;
  logic          out_last_r, out_last_nxt;

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  byte_t         wr_data, rd_data;

  logic          in_fire, out_fire;
  byte_t         sum_fin;
  logic          hit_now, found_fin;
  logic [AW-1:0] k_fin;

  scf_store #(
    .DEPTH (FRAME_BYTES),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;

  // Final checksum and resync point once the last stored byte is read
  assign sum_fin   = sum_r + rd_data;
  assign hit_now   = (rd_data == sync_r);
  assign found_fin = found_r || hit_now;
  assign k_fin     = found_r ? found_idx_r : d_idx_r;

  // Sequencer: accept, check, move and emit
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    scan_addr_nxt = scan_addr_r;
    issue_nxt     = issue_r;
    dv_nxt        = 1'b0;
    d_idx_nxt     = d_idx_r;
    sum_nxt       = sum_r;
    ck_nxt        = ck_r;
    found_nxt     = found_r;
    found_idx_nxt = found_idx_r;
    dst_nxt       = dst_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = in_rx_byte;
    rd_en         = 1'b0;
    rd_addr       = scan_addr_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (fill_r == '0) begin
            // Hunt for the sync byte
            if (in_rx_byte == sync_r) begin
              wr_en    = 1'b1;
              fill_nxt = CW'(1);
            end
          end else begin
            // Append and start the check on the closing byte
            wr_en    = 1'b1;
            wr_addr  = fill_r[AW-1:0];
            fill_nxt = fill_r + CW'(1);
            if (fill_r == FILL_LAST) begin
              state_nxt     = S_CHECK;
              scan_addr_nxt = CK_ADDR;
              issue_nxt     = 1'b1;
              sum_nxt       = '0;
              found_nxt     = 1'b0;
            end
          end
        end
      end

      S_CHECK: begin
        // Stream bytes 1 to the end through the read port
        if (issue_r) begin
          rd_en     = 1'b1;
          dv_nxt    = 1'b1;
          d_idx_nxt = scan_addr_r;
          if (scan_addr_r == LAST_ADDR) begin
            issue_nxt = 1'b0;
          end else begin
            scan_addr_nxt = scan_addr_r + AW'(1);
          end
        end
        // Capture the checksum byte, accumulate the sum and note the first sync byte past position 0
        if (dv_r) begin
          if (d_idx_r == CK_ADDR) begin
            ck_nxt = rd_data;
          end else begin
            sum_nxt = sum_fin;
          end
          if (!found_r && hit_now) begin
            found_nxt     = 1'b1;
            found_idx_nxt = d_idx_r;
          end
          if (d_idx_r == LAST_ADDR) begin
            if (sum_fin == ck_r) begin
              state_nxt     = S_EMIT;
              scan_addr_nxt = '0;
              issue_nxt     = 1'b1;
            end else if (found_fin) begin
              state_nxt     = S_COPY;
              scan_addr_nxt = k_fin;
              issue_nxt     = 1'b1;
              dst_nxt       = '0;
              fill_nxt      = FILL_FULL - CW'(k_fin);
            end else begin
              state_nxt = S_IDLE;
              fill_nxt  = '0;
            end
          end
        end
      end

      S_COPY: begin
        // Read the tail ahead and write it to the front
        if (issue_r) begin
          rd_en     = 1'b1;
          dv_nxt    = 1'b1;
          d_idx_nxt = scan_addr_r;
          if (scan_addr_r == LAST_ADDR) begin
            issue_nxt = 1'b0;
          end else begin
            scan_addr_nxt = scan_addr_r + AW'(1);
          end
        end
        if (dv_r) begin
          wr_en   = 1'b1;
          wr_addr = dst_r;
          wr_data = rd_data;
          dst_nxt = dst_r + AW'(1);
          if (d_idx_r == LAST_ADDR) begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_EMIT: begin
        // Drop the beat the sink took
        if (out_fire) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt = S_IDLE;
            fill_nxt  = '0;
          end
        end
        // Fetch the next byte once the output register frees up
        if (issue_r && !dv_r && (!out_valid_r || out_fire)) begin
          rd_en     = 1'b1;
          dv_nxt    = 1'b1;
          d_idx_nxt = scan_addr_r;
          if (scan_addr_r == LAST_ADDR) begin
            issue_nxt = 1'b0;
          end else begin
            scan_addr_nxt = scan_addr_r + AW'(1);
          end
        end
        // Load the output register
        if (dv_r) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = rd_data;
          out_idx_nxt   = IDX_W'(d_idx_r);
          out_last_nxt  = (d_idx_r == LAST_ADDR);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      sync_r      <= SYNC_RESET;
      issue_r     <= 1'b0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      issue_r     <= issue_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        sync_r <= cfg_wr_data;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    scan_addr_r <= scan_addr_nxt;
    d_idx_r     <= d_idx_nxt;
    sum_r       <= sum_nxt;
    ck_r        <= ck_nxt;
    found_r     <= found_nxt;
    found_idx_r <= found_idx_nxt;
    dst_r       <= dst_nxt;
    out_byte_r  <= out_byte_nxt;
    out_idx_r   <= out_idx_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_frame_byte    = out_byte_r;
  assign out_byte_index    = out_idx_r;
  assign out_last_of_frame = out_last_r;

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input accepted while a frame beat is pending");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (fill_r <= FILL_LAST))
    else $error("fill count reached a full frame while idle");

  a_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("store read and write hit the same entry");

  a_frame_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_last_of_frame) |=> (in_ready && fill_r == '0))
    else $error("store not emptied after the last frame beat");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_r && state_r == S_EMIT) |-> !out_valid_r)
    else $error("output register overwritten before it was taken");
`endif

endmodule

// ===== hdl/scf_store.sv =====
// ----------------------------------------------------------------------------
// scf_store: frame byte store
//
// Simple dual-port memory: one write port and one read port, with the read
// data registered. Contents are undefined until written.
// ----------------------------------------------------------------------------
module scf_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  scf_pkg::byte_t  wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output scf_pkg::byte_t  rd_data
);
  import scf_pkg::*;

  byte_t mem [DEPTH];
  byte_t rd_data_r;

  // Write and read the array; a read sees the old data on a same-entry write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
